@@ hw/rtl/bc7m6_pkg.sv @@
// Shared types, constants and the weight table for the BC7 mode-6 decoder.
package bc7m6_pkg;

  localparam int NumTexels   = 16;
  localparam int NumChannels = 4;

  // Mode field: low seven bits of the block
  localparam logic [6:0] ModeMode6 = 7'h40;

  // Bit offsets in the 128-bit block
  localparam int EpBase    = 7;
  localparam int EpStride  = 14;
  localparam int EpBits    = 7;
  localparam int PBit0Pos  = 63;
  localparam int PBit1Pos  = 64;
  localparam int IdxBase   = 65;
  localparam int IdxBits   = 128 - IdxBase;
  localparam int AnchorLen = 3;
  localparam int IdxLen    = 4;

  // Rounding term and the full-scale weight
  localparam logic [13:0] RoundBias = 14'd32;
  localparam logic [6:0]  WeightOne = 7'd64;

  typedef logic [NumChannels-1:0][7:0] endpoint_t;

  // Side information that travels with each texel item
  typedef struct packed {
    logic [3:0] texel_index;
    logic       mode_ok;
    logic       last;
  } texel_meta_t;

  // 4-bit interpolation weights
  function automatic logic [6:0] weight_lookup(input logic [3:0] idx);
    logic [6:0] w;
    unique case (idx)
      4'd0:    w = 7'd0;
      4'd1:    w = 7'd4;
      4'd2:    w = 7'd9;
      4'd3:    w = 7'd13;
      4'd4:    w = 7'd17;
      4'd5:    w = 7'd21;
      4'd6:    w = 7'd26;
      4'd7:    w = 7'd30;
      4'd8:    w = 7'd34;
      4'd9:    w = 7'd38;
      4'd10:   w = 7'd43;
      4'd11:   w = 7'd47;
      4'd12:   w = 7'd51;
      4'd13:   w = 7'd55;
      4'd14:   w = 7'd60;
      default: w = 7'd64;
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/bc7m6_unpack.sv @@
// Block register and texel sequencer: unpacks endpoints and walks the sixteen indices.
module bc7m6_unpack import bc7m6_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [63:0]  block_low,
  input  logic [63:0]  block_high,
  output logic         tx_valid,
  input  logic         tx_ready,
  output endpoint_t    tx_e0,
  output endpoint_t    tx_e1,
  output logic [3:0]   tx_widx,
  output texel_meta_t  tx_meta
);

  logic                 busy;
  logic                 mode_ok;
  logic [3:0]           count;
  logic [IdxBits-1:0]   idx_bits;
  endpoint_t            ep0;
  endpoint_t            ep1;

  logic [127:0]         blk;
  logic                 blk_mode6;
  logic                 take;
  logic                 load;
  endpoint_t            dec_e0;
  endpoint_t            dec_e1;

  assign blk       = {block_high, block_low};
  assign blk_mode6 = (block_low[6:0] == ModeMode6);

  // Endpoint decode; a block of another mode gets zero endpoints so colors come out zero
  always_comb begin
    for (int c = 0; c < NumChannels; c++) begin
      dec_e0[c] = blk_mode6 ? {blk[EpBase + c*EpStride +: EpBits], blk[PBit0Pos]} : 8'd0;
      dec_e1[c] = blk_mode6 ?
                  {blk[EpBase + EpBits + c*EpStride +: EpBits], blk[PBit1Pos]} : 8'd0;
    end
  end

  // Current texel item
  assign tx_valid            = busy;
  assign tx_e0               = ep0;
  assign tx_e1               = ep1;
  assign tx_widx             = (count == 4'd0) ? {1'b0, idx_bits[AnchorLen-1:0]}
                                               : idx_bits[IdxLen-1:0];
  assign tx_meta.texel_index = count;
  assign tx_meta.mode_ok     = mode_ok;
  assign tx_meta.last        = !mode_ok || (count == 4'(NumTexels - 1));

  assign take     = busy && tx_ready;
  assign in_ready = !busy || (take && tx_meta.last);
  assign load     = in_valid && in_ready;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (load) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (take) begin
      if (tx_meta.last) begin
        busy <= 1'b0;
      end
      count <= count + 4'd1;
    end
  end

  // Payload: endpoints and the index shift register
  always_ff @(posedge clk) begin
    if (load) begin
      mode_ok  <= blk_mode6;
      ep0      <= dec_e0;
      ep1      <= dec_e1;
      idx_bits <= blk_mode6 ? blk[127:IdxBase] : '0;
    end else if (take) begin
      idx_bits <= (count == 4'd0) ? (idx_bits >> AnchorLen) : (idx_bits >> IdxLen);
    end
  end

endmodule

@@ hw/rtl/bc7m6_interp.sv @@
// Three-stage interpolation pipeline: weight lookup, products, rounded sum.
module bc7m6_interp import bc7m6_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         tx_valid,
  output logic         tx_ready,
  input  endpoint_t    tx_e0,
  input  endpoint_t    tx_e1,
  input  logic [3:0]   tx_widx,
  input  texel_meta_t  tx_meta,
  output logic         out_valid,
  input  logic         out_ready,
  output endpoint_t    out_color,
  output texel_meta_t  out_meta
);

  logic                              s1_valid;
  logic                              s2_valid;
  logic                              s3_valid;
  logic                              s1_ready;
  logic                              s2_ready;
  logic                              s3_ready;

  endpoint_t                         s1_e0;
  endpoint_t                         s1_e1;
  logic [6:0]                        s1_w;
  texel_meta_t                       s1_meta;

  logic [NumChannels-1:0][13:0]      s2_p0;
  logic [NumChannels-1:0][13:0]      s2_p1;
  texel_meta_t                       s2_meta;

  endpoint_t                         s3_color;
  texel_meta_t                       s3_meta;

  logic [NumChannels-1:0][13:0]      sum;

  // Stage handshakes: a stage moves when empty or when the next one takes its item
  assign s3_ready = !s3_valid || out_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign tx_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= tx_valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
    end
  end

  // Stage 1: weight lookup
  always_ff @(posedge clk) begin
    if (s1_ready && tx_valid) begin
      s1_e0   <= tx_e0;
      s1_e1   <= tx_e1;
      s1_w    <= weight_lookup(tx_widx);
      s1_meta <= tx_meta;
    end
  end

  // Stage 2: weighted endpoint products per channel
  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      for (int c = 0; c < NumChannels; c++) begin
        s2_p0[c] <= 14'(WeightOne - s1_w) * 14'(s1_e0[c]);
        s2_p1[c] <= 14'(s1_w) * 14'(s1_e1[c]);
      end
      s2_meta <= s1_meta;
    end
  end

  // Stage 3: rounded sum, divide by 64
  always_comb begin
    for (int c = 0; c < NumChannels; c++) begin
      sum[c] = s2_p0[c] + s2_p1[c] + RoundBias;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      for (int c = 0; c < NumChannels; c++) begin
        s3_color[c] <= sum[c][13:6];
      end
      s3_meta <= s2_meta;
    end
  end

  assign out_valid = s3_valid;
  assign out_color = s3_color;
  assign out_meta  = s3_meta;

endmodule

@@ hw/rtl/bc7_mode6_block_decoder.sv @@
// Top level of the BC7 mode-6 block decoder.
//
//   channel  handshake            payload
//   input    in_valid/in_ready    block_low, block_high
//   output   out_valid/out_ready  texel_index, red, green, blue, alpha, mode_ok, last
//
// A mode-6 block yields sixteen texels, one per cycle while out_ready is high; another
// mode yields one item. The block register takes the next block in the cycle its last
// texel leaves, so blocks follow back to back.
// The texel rate is set by the single interpolation lane (four channels in parallel).
// rst (synchronous) empties the block register and all pipeline stages.
// out_ready low holds every occupied stage in place; nothing is lost or repeated.
module bc7_mode6_block_decoder import bc7m6_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] block_low,
  input  logic [63:0] block_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  texel_index,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic        mode_ok,
  output logic        last
);

  logic         tx_valid;
  logic         tx_ready;
  endpoint_t    tx_e0;
  endpoint_t    tx_e1;
  logic [3:0]   tx_widx;
  texel_meta_t  tx_meta;
  endpoint_t    out_color;
  texel_meta_t  out_meta;

  // Block register and texel sequencer
  bc7m6_unpack u_unpack (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .block_low  (block_low),
    .block_high (block_high),
    .tx_valid   (tx_valid),
    .tx_ready   (tx_ready),
    .tx_e0      (tx_e0),
    .tx_e1      (tx_e1),
    .tx_widx    (tx_widx),
    .tx_meta    (tx_meta)
  );

  // Interpolation pipeline
  bc7m6_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .tx_valid  (tx_valid),
    .tx_ready  (tx_ready),
    .tx_e0     (tx_e0),
    .tx_e1     (tx_e1),
    .tx_widx   (tx_widx),
    .tx_meta   (tx_meta),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_color (out_color),
    .out_meta  (out_meta)
  );

  // Channel order: red, green, blue, alpha
  assign red         = out_color[0];
  assign green       = out_color[1];
  assign blue        = out_color[2];
  assign alpha       = out_color[3];
  assign texel_index = out_meta.texel_index;
  assign mode_ok     = out_meta.mode_ok;
  assign last        = out_meta.last;

endmodule

@@ test/bc7_texel_checker.sv @@
// Watches both channels of the BC7 mode-6 decoder, predicts every texel and compares.
module bc7_texel_checker import bc7m6_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [63:0] block_low,
  input  logic [63:0] block_high,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  texel_index,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [7:0]  alpha,
  input  logic        mode_ok,
  input  logic        last,
  output int          error_count,
  output int          texels_pending,
  output int          blocks_seen,
  output int          mode6_blocks,
  output int          texels_seen
);

  // Interpolation ramp for 4-bit indices, entry 15 leftmost
  localparam logic [15:0][6:0] RampWeight = {
    7'd64, 7'd60, 7'd55, 7'd51, 7'd47, 7'd43, 7'd38, 7'd34,
    7'd30, 7'd26, 7'd21, 7'd17, 7'd13, 7'd9,  7'd4,  7'd0
  };

  typedef struct packed {
    logic [3:0] texel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       mode_ok;
    logic       last;
  } texel_t;

  texel_t expected_texels[$];

  initial begin
    error_count    = 0;
    texels_pending = 0;
    blocks_seen    = 0;
    mode6_blocks   = 0;
    texels_seen    = 0;
  end

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t: texel mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    error_count++;
  endtask

  // Queue the texels one block decodes to
  task automatic decode_block(input logic [63:0] lo, input logic [63:0] hi);
    logic [127:0] bits;
    logic [7:0]   ep0 [4];
    logic [7:0]   ep1 [4];
    logic [7:0]   chan [4];
    logic [3:0]   code;
    int           w;
    texel_t       tx;
    bits = {hi, lo};
    blocks_seen++;
    if (bits[6:0] != ModeMode6) begin
      // unsupported mode: a single zero texel that closes the block
      tx = '0;
      tx.last = 1'b1;
      expected_texels.push_back(tx);
      return;
    end
    mode6_blocks++;
    // endpoints: 7 bits per channel, p-bit appended below
    for (int c = 0; c < 4; c++) begin
      ep0[c] = {bits[7 + 14*c +: 7], bits[63]};
      ep1[c] = {bits[14 + 14*c +: 7], bits[64]};
    end
    for (int t = 0; t < 16; t++) begin
      if (t == 0) code = {1'b0, bits[65 +: 3]};
      else        code = bits[68 + 4*(t-1) +: 4];
      w = int'(RampWeight[code]);
      for (int c = 0; c < 4; c++)
        chan[c] = 8'(((64 - w) * int'(ep0[c]) + w * int'(ep1[c]) + 32) >> 6);
      tx.texel_index = 4'(t);
      tx.red         = chan[0];
      tx.green       = chan[1];
      tx.blue        = chan[2];
      tx.alpha       = chan[3];
      tx.mode_ok     = 1'b1;
      tx.last        = (t == 15);
      expected_texels.push_back(tx);
    end
  endtask

  // Sample both channels at each edge
  always @(posedge clk) begin
    texel_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        decode_block(block_low, block_high);
      if (out_valid && out_ready) begin
        texels_seen++;
        if (expected_texels.size() == 0) begin
          report_mismatch("unexpected texel, index", -1, int'(texel_index));
        end else begin
          want = expected_texels.pop_front();
          if (texel_index !== want.texel_index)
            report_mismatch("texel_index", want.texel_index, texel_index);
          if (red !== want.red)     report_mismatch("red", want.red, red);
          if (green !== want.green) report_mismatch("green", want.green, green);
          if (blue !== want.blue)   report_mismatch("blue", want.blue, blue);
          if (alpha !== want.alpha) report_mismatch("alpha", want.alpha, alpha);
          if (mode_ok !== want.mode_ok) report_mismatch("mode_ok", want.mode_ok, mode_ok);
          if (last !== want.last)   report_mismatch("last", want.last, last);
        end
      end
    end
    texels_pending = expected_texels.size();
  end

endmodule

@@ test/tb.sv @@
// Stimulus, pacing and verdict for the BC7 mode-6 block decoder.
module tb import bc7m6_pkg::*;;

  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 250;
  localparam int PhaseBlocks = 90;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] block_low;
  logic [63:0] block_high;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  texel_index;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic        mode_ok;
  logic        last;

  int error_count;
  int texels_pending;
  int blocks_seen;
  int mode6_blocks;
  int texels_seen;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  bit hold_request = 1'b0;
  int cycle_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bc7_mode6_block_decoder DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .block_low(block_low), .block_high(block_high),
    .out_valid(out_valid), .out_ready(out_ready),
    .texel_index(texel_index), .red(red), .green(green), .blue(blue), .alpha(alpha),
    .mode_ok(mode_ok), .last(last)
  );

  bc7_texel_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .block_low(block_low), .block_high(block_high),
    .out_valid(out_valid), .out_ready(out_ready),
    .texel_index(texel_index), .red(red), .green(green), .blue(blue), .alpha(alpha),
    .mode_ok(mode_ok), .last(last),
    .error_count(error_count), .texels_pending(texels_pending),
    .blocks_seen(blocks_seen), .mode6_blocks(mode6_blocks), .texels_seen(texels_seen)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d texels outstanding", cycle_count, texels_pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Output side: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        for (int k = 0; k < HoldCycles; k++) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Assemble a mode-6 block; endpoint channel order is r, g, b, a
  function automatic logic [127:0] pack_mode6(input logic [3:0][6:0] ep0,
                                              input logic [3:0][6:0] ep1,
                                              input logic p0, input logic p1,
                                              input logic [62:0] indices);
    logic [63:0] lo;
    lo = {p0, ep1[3], ep0[3], ep1[2], ep0[2], ep1[1], ep0[1], ep1[0], ep0[0], ModeMode6};
    return {indices, p1, lo};
  endfunction

  // Mostly mode-6 blocks with random content, some other modes as noise
  function automatic logic [127:0] random_block();
    logic [63:0] lo;
    logic [63:0] hi;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    if ($urandom_range(99) < 80) lo[6:0] = ModeMode6;
    else if (lo[6:0] == ModeMode6) lo[$urandom_range(6)] ^= 1'b1;
    return {hi, lo};
  endfunction

  // Offer one item after a random idle gap; returns once it is accepted
  task automatic offer_block(input logic [127:0] blk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    block_low  <= blk[63:0];
    block_high <= blk[127:64];
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering until every expected texel is out, then let the pipe settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (texels_pending != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [62:0] sweep;
    logic [62:0] ones_idx;
    int          send_pct [4];
    int          stall_pct [4];
    send_pct  = '{0, 56, 0, 17};
    stall_pct = '{0, 0, 56, 17};

    rst        = 1'b1;
    in_valid   = 1'b0;
    block_low  = '0;
    block_high = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // anchor 7, then texel t carries index t
    sweep = 63'd7;
    for (int t = 1; t < 16; t++) sweep[3 + 4*(t-1) +: 4] = 4'(t);
    ones_idx = '1;

    // Directed: field extremes, every index value, p-bits, non-mode-6 patterns
    offer_block('0);
    offer_block('1);
    offer_block({64'd0, 57'd0, ModeMode6});
    offer_block(pack_mode6('1, '1, 1'b1, 1'b1, ones_idx));
    offer_block(pack_mode6('0, '1, 1'b0, 1'b1, sweep));
    offer_block(pack_mode6('1, '0, 1'b1, 1'b0, sweep));
    offer_block(pack_mode6('0, '0, 1'b1, 1'b0, sweep));
    offer_block(pack_mode6('0, '0, 1'b0, 1'b1, ~sweep));
    offer_block(pack_mode6({7'h2a, 7'h55, 7'h00, 7'h7f}, {7'h55, 7'h2a, 7'h7f, 7'h00},
                           1'b0, 1'b1, {60'h0, 3'd0}));
    offer_block(pack_mode6({7'h01, 7'h40, 7'h3f, 7'h7e}, {7'h7e, 7'h3f, 7'h40, 7'h01},
                           1'b1, 1'b1, {60'hfff_ffff_ffff_ffff, 3'd0}));
    // bit 7 belongs to red endpoint 0, not to the mode field
    offer_block({64'd0, 64'h0000_0000_0000_00c0});
    offer_block({64'd0, 64'h0000_0000_0000_0080});
    for (int k = 0; k < 6; k++)
      offer_block({$urandom, $urandom, $urandom, 25'($urandom), 7'(1 << k)});
    offer_block({$urandom, $urandom, $urandom, 25'($urandom), 7'h41});
    offer_block({$urandom, $urandom, $urandom, 25'($urandom), 7'h7f});
    offer_block({$urandom, $urandom, $urandom, 25'($urandom), 7'h60});
    wait_drained();

    // Random: four pacing phases, each ending with a full drain
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct    = send_pct[ph];
      receiver_stall_pct = stall_pct[ph];
      if (ph == 0) hold_request = 1'b1;
      for (int n = 0; n < PhaseBlocks; n++) offer_block(random_block());
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("decoded %0d blocks (%0d mode 6, rest other modes), %0d texels checked,",
             blocks_seen, mode6_blocks, texels_seen);
    $display("under free flow, sparse input, output back-pressure and a long output hold");
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
